// ===== src/jms_pkg.sv =====
// ----------------------------------------------------------------------------
// jms_pkg: shared types and constants for the jump motor sequencer
// Request codes, drive codes, mode codes, register indexes and state records.
// ----------------------------------------------------------------------------
package jms_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [1:0] REQ_SERVICE = 2'd0;
  localparam logic [1:0] REQ_MODE1   = 2'd1;
  localparam logic [1:0] REQ_MODE2   = 2'd2;

  localparam logic [1:0] DRIVE_STOP = 2'd0;
  localparam logic [1:0] DRIVE_FWD  = 2'd1;
  localparam logic [1:0] DRIVE_BACK = 2'd2;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_TWO  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_M1_RUN    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_M1_TRIG   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_M2_WIND   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_M2_BACK   = 3'd4;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] mode1_run_ticks;
    logic [15:0] mode1_trigger_ticks;
    logic [15:0] mode2_wind_ticks;
    logic [15:0] mode2_back_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  active_mode;
    logic        wound_ready;
    logic        switch_hit;
    logic        timeout_running;
    logic [15:0] phase_timer;
    logic        debounce_running;
    logic [7:0]  debounce_timer;
    logic        switch_state;
    logic [1:0]  drive_state;
  } seq_state_t;

  typedef struct packed {
    logic [1:0] motor_drive;
    logic       busy_res;
    logic       switch_level;
    logic       switch_event;
  } result_t;

endpackage

// ===== src/jms_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// jms_cfg_regs: configuration register file
// Write-only timing registers, loaded with their defaults at reset.
// ----------------------------------------------------------------------------
module jms_cfg_regs
  import jms_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: cfg_nxt.debounce_ticks      = cfg_wdata[7:0];
        CFG_M1_RUN:   cfg_nxt.mode1_run_ticks     = cfg_wdata;
        CFG_M1_TRIG:  cfg_nxt.mode1_trigger_ticks = cfg_wdata;
        CFG_M2_WIND:  cfg_nxt.mode2_wind_ticks    = cfg_wdata;
        CFG_M2_BACK:  cfg_nxt.mode2_back_ticks    = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks      <= 8'd20;
      cfg_r.mode1_run_ticks     <= 16'd1000;
      cfg_r.mode1_trigger_ticks <= 16'd200;
      cfg_r.mode2_wind_ticks    <= 16'd3000;
      cfg_r.mode2_back_ticks    <= 16'd300;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/jms_step.sv =====
// ----------------------------------------------------------------------------
// jms_step: next-state logic for one request
// Timer countdown, switch debounce and the mode machine, all combinational.
// ----------------------------------------------------------------------------
module jms_step
  import jms_pkg::*;
(
  input  cfg_t       cfg,
  input  seq_state_t cur,
  input  logic [1:0] req_type,
  input  logic [7:0] elapsed_ticks,
  input  logic       switch_raw,
  output seq_state_t nxt,
  output result_t    res
);

  logic [15:0] elapsed_ext;
  logic        ev;
  logic        fall;
  logic        expired;

  assign elapsed_ext = {8'd0, elapsed_ticks};

  always_comb begin
    nxt = cur;
    ev = 1'b0;
    fall = 1'b0;
    expired = 1'b0;
    case (req_type)
      REQ_SERVICE: begin
        // count down running timers, stopping at zero
        if (cur.debounce_running) begin
          nxt.debounce_timer = (cur.debounce_timer > elapsed_ticks) ?
                               cur.debounce_timer - elapsed_ticks : 8'd0;
        end
        if (cur.timeout_running) begin
          nxt.phase_timer = (cur.phase_timer > elapsed_ext) ?
                            cur.phase_timer - elapsed_ext : 16'd0;
        end

        if (switch_raw != cur.switch_state) begin
          if (cur.debounce_running) begin
            if (nxt.debounce_timer == 8'd0) begin
              ev = 1'b1;
              nxt.switch_state = ~cur.switch_state;
              nxt.debounce_running = 1'b0;
            end
          end else begin
            nxt.debounce_running = 1'b1;
            nxt.debounce_timer = cfg.debounce_ticks;
          end
        end else begin
          nxt.debounce_running = 1'b0;
        end

        fall = ev && !nxt.switch_state;

        case (cur.active_mode)
          MODE_IDLE: ;
          MODE_ONE: begin
            if (fall) begin
              nxt.phase_timer = cfg.mode1_trigger_ticks;
              nxt.timeout_running = 1'b1;
            end
            expired = nxt.timeout_running && (nxt.phase_timer == 16'd0);
            if (expired) begin
              nxt.drive_state = DRIVE_STOP;
              nxt.active_mode = MODE_IDLE;
              nxt.timeout_running = 1'b0;
            end
          end
          MODE_TWO: begin
            expired = nxt.timeout_running && (nxt.phase_timer == 16'd0);
            if (cur.wound_ready) begin
              if (expired) begin
                nxt.drive_state = DRIVE_STOP;
                nxt.active_mode = MODE_IDLE;
                nxt.timeout_running = 1'b0;
                nxt.wound_ready = 1'b0;
                nxt.switch_hit = 1'b0;
              end
            end else if (cur.switch_hit) begin
              // back-off done: stop and wait for fire
              if (expired) begin
                nxt.drive_state = DRIVE_STOP;
                nxt.timeout_running = 1'b0;
                nxt.wound_ready = 1'b1;
              end
            end else if (ev) begin
              // a rising edge skips the timeout check in this service
              if (fall) begin
                nxt.drive_state = DRIVE_BACK;
                nxt.phase_timer = cfg.mode2_back_ticks;
                nxt.timeout_running = 1'b1;
                nxt.switch_hit = 1'b1;
              end
            end else if (expired) begin
              nxt.drive_state = DRIVE_STOP;
              nxt.active_mode = MODE_IDLE;
              nxt.timeout_running = 1'b0;
              nxt.wound_ready = 1'b0;
              nxt.switch_hit = 1'b0;
            end
          end
          default: begin
            nxt.drive_state = DRIVE_STOP;
            nxt.active_mode = MODE_IDLE;
          end
        endcase
      end
      REQ_MODE1: begin
        if (cur.active_mode == MODE_IDLE) begin
          nxt.active_mode = MODE_ONE;
          nxt.phase_timer = cfg.mode1_run_ticks;
          nxt.timeout_running = 1'b1;
          nxt.drive_state = DRIVE_FWD;
        end
      end
      REQ_MODE2: begin
        if (cur.active_mode == MODE_IDLE) begin
          nxt.active_mode = MODE_TWO;
          nxt.drive_state = DRIVE_FWD;
          nxt.phase_timer = cfg.mode2_wind_ticks;
          nxt.timeout_running = 1'b1;
        end else if (cur.active_mode == MODE_TWO && cur.wound_ready) begin
          nxt.drive_state = DRIVE_BACK;
          nxt.phase_timer = cfg.mode2_back_ticks;
          nxt.timeout_running = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res.motor_drive  = nxt.drive_state;
  assign res.busy_res     = (nxt.active_mode != MODE_IDLE);
  assign res.switch_level = nxt.switch_state;
  assign res.switch_event = ev;

endmodule

// ===== src/jump_motor_sequencer_unit.sv =====
// Path: an accepted request is held in the input register, then moves into
// the result register. Throughput: one request per cycle while out_ready is
// high; the sequencer state updates in the same cycle the result register
// loads, so consecutive requests chain directly.
// Reset (rst_n low, synchronous): pipeline empty, sequencer idle, motor stopped,
// timers cleared, timing registers at their defaults.
// ----------------------------------------------------------------------------
// jump_motor_sequencer_unit: spring jump motor sequencer
// Input register, state update with result register, and configuration port.
// ----------------------------------------------------------------------------
module jump_motor_sequencer_unit
  import jms_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic [7:0]          in_elapsed_ticks,
  input  logic                in_switch_raw,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_motor_drive,
  output logic                out_busy_res,
  output logic                out_switch_level,
  output logic                out_switch_event,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t       cfg;
  seq_state_t state_r;
  seq_state_t state_nxt;
  result_t    res_nxt;
  result_t    res_r;

  logic       in_valid_r;
  logic [1:0] req_type_r;
  logic [7:0] elapsed_r;
  logic       raw_r;
  logic       out_valid_r;
  logic       advance;

  jms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  jms_step u_step (
    .cfg           (cfg),
    .cur           (state_r),
    .req_type      (req_type_r),
    .elapsed_ticks (elapsed_r),
    .switch_raw    (raw_r),
    .nxt           (state_nxt),
    .res           (res_nxt)
  );

  // move the held request into the result register when it is free
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_type_r <= in_req_type;
      elapsed_r  <= in_elapsed_ticks;
      raw_r      <= in_switch_raw;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_motor_drive  = res_r.motor_drive;
  assign out_busy_res     = res_r.busy_res;
  assign out_switch_level = res_r.switch_level;
  assign out_switch_event = res_r.switch_event;

endmodule
